/* design/rwsd_pkg.sv */
package rwsd_pkg;

    localparam int RWSD_MODULES = 2;

    localparam logic [31:0] FRAME_MASK  = 32'h8080_8080;
    localparam logic [31:0] FRAME_VALUE = 32'h8000_0000;

    localparam logic [27:0] ADC_MASK    = 28'h068_0000;
    localparam logic [27:0] ADC_HI_VAL  = 28'h000_0000;
    localparam logic [27:0] ADC_LO_VAL  = 28'h008_0000;
    localparam logic [27:0] TDC_MASK    = 28'h060_1000;
    localparam logic [27:0] TDC_LEAD    = 28'h020_1000;
    localparam logic [27:0] TDC_TRAIL   = 28'h020_0000;
    localparam logic [27:0] SCALER_MASK = 28'h060_0000;
    localparam logic [27:0] SCALER_VAL  = 28'h040_0000;

    typedef enum logic [2:0] {
        ST_HEADER     = 3'd0,
        ST_DATA       = 3'd1,
        ST_FRAME_ERR  = 3'd2,
        ST_NOT_HEADER = 3'd3,
        ST_ZERO_DATA  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        HC_ADC_HIGH    = 3'd0,
        HC_ADC_LOW     = 3'd1,
        HC_TDC_LEAD    = 3'd2,
        HC_TDC_TRAIL   = 3'd3,
        HC_SCALER      = 3'd4,
        HC_UNKNOWN     = 3'd5
    } t_hit_class;

    typedef struct packed {
        t_status    status;
        t_hit_class hit_class;
        logic [6:0]  channel;
        logic [11:0] sample_value;
        logic        over_range;
        logic [11:0] word_count;
        logic        event_end;
    } t_result;

endpackage

/* design/rwsd_if.sv */
interface rwsd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink (input valid, input raw_word, output ready);
endinterface

interface rwsd_result_if import rwsd_pkg::*;;
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/readout_word_stream_decoder_top.sv */
// Readout word stream decoder: takes one 32-bit readout word per cycle and
// returns exactly one result word for each, in order. A word passes an input
// register and the decode result sits in an output register; throughput is one
// word per clock whenever the result side takes words, and a stall on the result
// side backs up through both registers. Each event is MODULES modules, each a
// header carrying a 12-bit word count followed by that many data words. Frame
// errors, a missing header or an all-zero data word report an error status and
// restart at the first module's header.
module readout_word_stream_decoder_top
    import rwsd_pkg::*;
#(
    parameter int MODULES = RWSD_MODULES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rwsd_word_if.sink            i_word,
    rwsd_result_if.source        o_result
);

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MODULES - 1);

    logic              r_in_valid;
    logic [31:0]       r_in_word;
    logic              r_out_valid;
    t_result           r_out;

    logic              r_in_payload;
    logic [11:0]       r_words_left;
    logic [IDX_W-1:0]  r_module_index;

    logic              n_in_payload;
    logic [11:0]       n_words_left;
    logic [IDX_W-1:0]  n_module_index;
    t_result           n_out;

    logic              out_free;
    logic              s1_go;
    logic              frame_ok;
    logic [27:0]       dec;
    logic [11:0]       words_dec;
    logic              last_module;
    t_hit_class        cls;

    assign out_free       = !r_out_valid || o_result.ready;
    assign s1_go          = r_in_valid && out_free;
    assign i_word.ready   = !r_in_valid || out_free;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    assign frame_ok    = (r_in_word & FRAME_MASK) == FRAME_VALUE;
    assign dec         = {r_in_word[30:24], r_in_word[22:16], r_in_word[14:8], r_in_word[6:0]};
    assign words_dec   = r_words_left - 12'd1;
    assign last_module = r_module_index == LAST_IDX;

    always_comb begin
        priority if ((dec & ADC_MASK) == ADC_HI_VAL) begin
            cls = HC_ADC_HIGH;
        end else if ((dec & ADC_MASK) == ADC_LO_VAL) begin
            cls = HC_ADC_LOW;
        end else if ((dec & TDC_MASK) == TDC_LEAD) begin
            cls = HC_TDC_LEAD;
        end else if ((dec & TDC_MASK) == TDC_TRAIL) begin
            cls = HC_TDC_TRAIL;
        end else if ((dec & SCALER_MASK) == SCALER_VAL) begin
            cls = HC_SCALER;
        end else begin
            cls = HC_UNKNOWN;
        end
    end

    always_comb begin
        n_out          = '0;
        n_out.status   = ST_HEADER;
        n_out.hit_class = HC_ADC_HIGH;
        n_in_payload   = r_in_payload;
        n_words_left   = r_words_left;
        n_module_index = r_module_index;
        priority if (!frame_ok) begin
            n_out.status   = ST_FRAME_ERR;
            n_in_payload   = 1'b0;
            n_words_left   = '0;
            n_module_index = '0;
        end else if (!r_in_payload) begin
            if (!dec[27]) begin
                n_out.status   = ST_NOT_HEADER;
                n_words_left   = '0;
                n_module_index = '0;
            end else begin
                n_out.status     = ST_HEADER;
                n_out.word_count = dec[11:0];
                if (dec[11:0] == 12'd0) begin
                    n_out.event_end = last_module;
                    n_module_index  = last_module ? '0 : r_module_index + IDX_W'(1);
                end else begin
                    n_in_payload = 1'b1;
                    n_words_left = dec[11:0];
                end
            end
        end else if (dec == 28'd0) begin
            n_out.status   = ST_ZERO_DATA;
            n_in_payload   = 1'b0;
            n_words_left   = '0;
            n_module_index = '0;
        end else begin
            n_out.status       = ST_DATA;
            n_out.hit_class    = cls;
            n_out.channel      = {r_module_index[0], dec[18:13]};
            n_out.sample_value = dec[11:0];
            n_out.over_range   = dec[12] && (cls == HC_ADC_HIGH || cls == HC_ADC_LOW);
            n_words_left       = words_dec;
            if (words_dec == 12'd0) begin
                n_in_payload    = 1'b0;
                n_out.event_end = last_module;
                n_module_index  = last_module ? '0 : r_module_index + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_in_payload   <= 1'b0;
            r_words_left   <= '0;
            r_module_index <= '0;
        end else begin
            if (i_word.valid && i_word.ready) begin
                r_in_valid <= 1'b1;
            end else if (s1_go) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (s1_go) begin
                r_in_payload   <= n_in_payload;
                r_words_left   <= n_words_left;
                r_module_index <= n_module_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_in_word <= i_word.raw_word;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

endmodule
